// ===== src/flywheel_spinup_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Flywheel spin-up sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef FLYWHEEL_SPINUP_SEQUENCER_UNIT_DEFINES_SVH
`define FLYWHEEL_SPINUP_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Types and constants shared by the flywheel spin-up sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fss_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_START_MODE = 2'd0,
    REG_ON_PULSE   = 2'd1,
    REG_SPIN_DELAY = 2'd2,
    REG_RANGE_HOLD = 2'd3
  } reg_idx_e;

  // Input word kinds, carried on tuser
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ENABLE = 2'd1,
    KIND_STICK  = 2'd2,
    KIND_START  = 2'd3
  } kind_e;

  // Start sequences selected by the start_mode register
  typedef enum logic [1:0] {
    START_NORMAL = 2'd0,
    START_RANGE  = 2'd1,
    START_MANUAL = 2'd2,
    START_NONE   = 2'd3
  } start_mode_e;

  // Shooter status codes
  typedef enum logic [1:0] {
    SHOOTER_OTHER   = 2'd0,
    SHOOTER_READY   = 2'd1,
    SHOOTER_RUNNING = 2'd2,
    SHOOTER_SPARE   = 2'd3
  } shooter_e;

  localparam logic [1:0]  START_MODE_RST = 2'd0;
  localparam logic [10:0] ON_PULSE_RST   = 11'd1500;
  localparam logic [11:0] SPIN_DELAY_RST = 12'd500;
  localparam logic [11:0] RANGE_HOLD_RST = 12'd2000;

  localparam logic [10:0] PULSE_MIN  = 11'd1000;
  localparam logic [10:0] PULSE_MAX  = 11'd2000;
  localparam logic [10:0] STICK_LOW  = 11'd1024;
  localparam logic [10:0] STICK_HIGH = 11'd1684;
  // floor(x * 1000 / 660) == (x * STICK_RECIP) >> STICK_SHIFT for x in 0..660
  localparam logic [21:0] STICK_RECIP = 22'd3177550;
  localparam int unsigned STICK_SHIFT = 21;

  typedef struct packed {
    logic [1:0]  start_mode;
    logic [10:0] on_pulse_us;
    logic [11:0] spin_delay_ms;
    logic [11:0] range_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        enable_request;
    logic [10:0] stick_value;
    logic [1:0]  shooter_status;
  } item_t;

  typedef struct packed {
    logic [10:0] pulse_us;
    logic        laser_en;
    logic        fire_req;
    logic        fire_halt;
    logic [2:0]  wheel_state;
  } result_t;

endpackage

// ===== src/fss_regs.sv =====
// ----------------------------------------------------------------------------
// fss_regs
// APB configuration registers of the flywheel spin-up sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fss_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fss_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fss_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output fss_pkg::cfg_t                   cfg_o
);
  import fss_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_mode    <= START_MODE_RST;
      cfg_q.on_pulse_us   <= ON_PULSE_RST;
      cfg_q.spin_delay_ms <= SPIN_DELAY_RST;
      cfg_q.range_hold_ms <= RANGE_HOLD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_START_MODE: cfg_q.start_mode    <= pwdata[1:0];
        REG_ON_PULSE:   cfg_q.on_pulse_us   <= pwdata[10:0];
        REG_SPIN_DELAY: cfg_q.spin_delay_ms <= pwdata[11:0];
        REG_RANGE_HOLD: cfg_q.range_hold_ms <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_START_MODE: prdata = {30'd0, cfg_q.start_mode};
      REG_ON_PULSE:   prdata = {21'd0, cfg_q.on_pulse_us};
      REG_SPIN_DELAY: prdata = {20'd0, cfg_q.spin_delay_ms};
      REG_RANGE_HOLD: prdata = {20'd0, cfg_q.range_hold_ms};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/fss_core.sv =====
// ----------------------------------------------------------------------------
// fss_core
// Sequencer state and single-pass next-state logic for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flywheel_spinup_sequencer_unit_defines.svh"

module fss_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  fss_pkg::item_t   item_i,
  input  fss_pkg::cfg_t    cfg_i,
  output fss_pkg::result_t result_o
);
  import fss_pkg::*;

  typedef enum logic [2:0] {
    ST_PREPARE     = 3'd0,
    ST_OFF         = 3'd1,
    ST_TURNING_ON  = 3'd2,
    ST_ON          = 3'd3,
    ST_TURNING_OFF = 3'd4,
    ST_CALIBRATING = 3'd5,
    ST_MANUAL      = 3'd6
  } wheel_state_e;

  wheel_state_e state_q, state_d;
  logic [11:0]  count_q, count_d;
  logic         phase_q, phase_d;
  logic [10:0]  pulse_q, pulse_d;
  logic         laser_q, laser_d;
  logic         start_pls, stop_pls;

  logic         expire;
  logic [11:0]  count_dec;
  logic [10:0]  stick_clamp;
  logic [9:0]   stick_off;
  logic [31:0]  stick_prod;
  logic [10:0]  manual_pulse;

  // Countdown: a value of zero or one expires on this tick
  assign expire    = (count_q <= 12'd1);
  assign count_dec = expire ? 12'd0 : count_q - 12'd1;

  // Stick map: clamp, offset, scale by 1000/660 through a reciprocal
  always_comb begin
    if (item_i.stick_value > STICK_HIGH) begin
      stick_clamp = STICK_HIGH;
    end else if (item_i.stick_value < STICK_LOW) begin
      stick_clamp = STICK_LOW;
    end else begin
      stick_clamp = item_i.stick_value;
    end
  end
  assign stick_off    = 10'(stick_clamp - STICK_LOW);
  assign stick_prod   = {22'd0, stick_off} * {10'd0, STICK_RECIP};
  assign manual_pulse = PULSE_MIN + stick_prod[STICK_SHIFT +: 11];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    phase_d   = phase_q;
    pulse_d   = pulse_q;
    laser_d   = laser_q;
    start_pls = 1'b0;
    stop_pls  = 1'b0;
    case (kind_e'(item_i.kind))
      KIND_TICK: begin
        case (state_q)
          ST_TURNING_ON: begin
            count_d = count_dec;
            if (expire) begin
              state_d   = ST_ON;
              start_pls = (item_i.shooter_status == SHOOTER_READY);
            end
          end
          ST_TURNING_OFF: begin
            count_d = count_dec;
            if (expire) begin
              state_d = ST_OFF;
              pulse_d = PULSE_MIN;
            end
          end
          ST_CALIBRATING: begin
            count_d = count_dec;
            if (expire) begin
              pulse_d = PULSE_MIN;
              if (!phase_q) begin
                phase_d = 1'b1;
                count_d = cfg_i.range_hold_ms;
              end else begin
                phase_d = 1'b0;
                state_d = ST_OFF;
              end
            end
          end
          default: ;
        endcase
      end
      KIND_ENABLE: begin
        if (item_i.enable_request && state_q == ST_OFF) begin
          state_d = ST_TURNING_ON;
          pulse_d = cfg_i.on_pulse_us;
          laser_d = 1'b1;
          count_d = cfg_i.spin_delay_ms;
        end else if (!item_i.enable_request &&
                     (state_q == ST_ON || state_q == ST_TURNING_ON)) begin
          state_d  = ST_TURNING_OFF;
          laser_d  = 1'b0;
          stop_pls = (item_i.shooter_status == SHOOTER_RUNNING);
          count_d  = cfg_i.spin_delay_ms;
        end
      end
      KIND_STICK: begin
        if (state_q == ST_MANUAL) begin
          pulse_d = manual_pulse;
        end
      end
      KIND_START: begin
        if (state_q == ST_PREPARE) begin
          case (start_mode_e'(cfg_i.start_mode))
            START_NORMAL: begin
              pulse_d = PULSE_MIN;
              state_d = ST_OFF;
            end
            START_RANGE: begin
              pulse_d = PULSE_MAX;
              phase_d = 1'b0;
              count_d = cfg_i.range_hold_ms;
              state_d = ST_CALIBRATING;
            end
            START_MANUAL: state_d = ST_MANUAL;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREPARE;
      count_q <= '0;
      phase_q <= 1'b0;
      pulse_q <= '0;
      laser_q <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      pulse_q <= pulse_d;
      laser_q <= laser_d;
    end
  end

  assign result_o.pulse_us    = pulse_d;
  assign result_o.laser_en    = laser_d;
  assign result_o.fire_req    = start_pls;
  assign result_o.fire_halt   = stop_pls;
  assign result_o.wheel_state = state_d;

  // Laser follows the spinning states exactly
  `FSS_ASSERT_SAME(a_laser_state, clk_i, rst_ni, 1'b1,
    laser_q == (state_q == ST_TURNING_ON || state_q == ST_ON),
    "laser level out of step with wheel state")
  // Countdown runs only in the timed states
  `FSS_ASSERT_SAME(a_count_idle, clk_i, rst_ni,
    (state_q == ST_PREPARE || state_q == ST_OFF || state_q == ST_ON ||
     state_q == ST_MANUAL),
    count_q == 12'd0, "countdown left pending outside a timed state")
  // A shooter start pulse lands the wheels in on
  `FSS_ASSERT_NEXT(a_start_on, clk_i, rst_ni, step_i && start_pls,
    state_q == ST_ON, "shooter start without reaching on")
  // A shooter stop pulse only comes with the turn-off command
  `FSS_ASSERT_NEXT(a_stop_off, clk_i, rst_ni, step_i && stop_pls,
    state_q == ST_TURNING_OFF && !laser_q, "shooter stop outside turn-off")

endmodule

// ===== src/flywheel_spinup_sequencer_unit.sv =====
// Flywheel spin-up sequencer for a pair of ESC-driven flywheel motors.
// Input stream (s_axis_*): one word per event; tuser carries the kind
// (tick, enable command, stick value, start) and tdata its arguments.
// Output stream (m_axis_*): exactly one result word per input word, in order,
// giving the shared pulse width, laser level, shooter start/stop pulses and
// the wheel state.
// APB port: four configuration registers at byte addresses 0, 4, 8, 12; write
// them only while no word is in flight.
// Path: each word passes the input register, then the result register.
// Throughput: one word per cycle while m_axis_tready is high, set by the
// single next-state pass in fss_core.
// Reset: the wheels wait in prepare with pulse 0 and laser off; registers
// return to normal mode, 1500 us, 500 ms and 2000 ms.
// Stall: when m_axis_tready is low the result register holds, the input
// register fills, and s_axis_tready drops only once both are occupied.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// flywheel_spinup_sequencer_unit
// Top level: stream registers around the sequencer core plus APB registers.
// ----------------------------------------------------------------------------
module flywheel_spinup_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // enable_request[0],
                                                         // stick_value[11:1],
                                                         // shooter_status[13:12], zero pad
  input  logic [1:0]                      s_axis_tuser,  // kind
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // pulse_us[10:0], laser_en[11],
                                                         // fire_req[12],
                                                         // fire_halt[13],
                                                         // wheel_state[16:14], zero pad
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fss_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fss_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fss_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import fss_pkg::*;

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q, in_valid_d;
  result_t core_res;
  result_t out_res_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    in_take;

  fss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held word through the core when the result slot is free
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  assign in_valid_d  = in_take | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on take, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.kind           <= s_axis_tuser;
      in_item_q.enable_request <= s_axis_tdata[0];
      in_item_q.stick_value    <= s_axis_tdata[11:1];
      in_item_q.shooter_status <= s_axis_tdata[13:12];
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  fss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_res_q.wheel_state, out_res_q.fire_halt,
                          out_res_q.fire_req, out_res_q.laser_en,
                          out_res_q.pulse_us};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Flywheel spin-up sequencer testbench
// Drives event words (ticks, enable commands, stick values, start) into the
// sequencer, predicts every result word from its own copy of the wheel state
// and the registers, and checks each result field by field. The start path
// (normal, calibration or manual) is picked from the seed, since the block
// only leaves prepare once per reset.
// ----------------------------------------------------------------------------
module tb;
  import fss_pkg::*;

  localparam int unsigned ITEMS_TOTAL  = 1150;    // input words to send
  localparam int unsigned LONG_HOLD    = 120;     // receiver hold-off, cycles
  localparam int unsigned SETTLE       = 8;       // covers the input and result registers
  localparam int unsigned RUN_LIMIT_NS = 5000000; // watchdog limit, ns
  localparam int unsigned PULSE_SPAN   = 32'(PULSE_MAX - PULSE_MIN);
  localparam int unsigned STICK_SPAN   = 32'(STICK_HIGH - STICK_LOW);

  typedef enum logic [2:0] {
    WS_PREPARE     = 3'd0,
    WS_OFF         = 3'd1,
    WS_TURNING_ON  = 3'd2,
    WS_ON          = 3'd3,
    WS_TURNING_OFF = 3'd4,
    WS_CALIBRATING = 3'd5,
    WS_MANUAL      = 3'd6
  } wheel_state_e;

  // --------------------------------------------------------------------------
  // Scoreboard: wheel-state predictor plus the queue of pending result words
  // --------------------------------------------------------------------------
  class spinup_scoreboard;
    logic [1:0]   start_mode;
    logic [10:0]  on_pulse;
    logic [11:0]  spin_delay;
    logic [11:0]  range_hold;
    wheel_state_e wheel;
    logic [11:0]  countdown;
    bit           range_phase;
    logic [10:0]  pulse;
    bit           laser;
    result_t      pending_q[$];
    int unsigned  words_in, words_acted, words_out, failures;
    bit [6:0]     states_seen;

    function new();
      start_mode  = START_MODE_RST;
      on_pulse    = ON_PULSE_RST;
      spin_delay  = SPIN_DELAY_RST;
      range_hold  = RANGE_HOLD_RST;
      wheel       = WS_PREPARE;
      countdown   = '0;
      range_phase = 1'b0;
      pulse       = '0;
      laser       = 1'b0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] val);
      case (idx)
        REG_START_MODE: start_mode = val[1:0];
        REG_ON_PULSE:   on_pulse   = val[10:0];
        REG_SPIN_DELAY: spin_delay = val[11:0];
        REG_RANGE_HOLD: range_hold = val[11:0];
        default: ;
      endcase
    endfunction

    // A loaded zero expires on the next tick, same as a one.
    function bit countdown_expires();
      if (countdown <= 12'd1) begin
        countdown = '0;
        return 1'b1;
      end
      countdown = countdown - 12'd1;
      return 1'b0;
    endfunction

    function void note_input(item_t it);
      result_t     r;
      bit          start_p, stop_p, acted;
      int unsigned v;
      start_p = 1'b0;
      stop_p  = 1'b0;
      acted   = 1'b0;
      words_in++;
      case (kind_e'(it.kind))
        KIND_TICK: begin
          // Ticks only matter while a timed phase runs.
          case (wheel)
            WS_TURNING_ON: begin
              acted = 1'b1;
              if (countdown_expires()) begin
                wheel   = WS_ON;
                start_p = (it.shooter_status == SHOOTER_READY);
              end
            end
            WS_TURNING_OFF: begin
              acted = 1'b1;
              if (countdown_expires()) begin
                wheel = WS_OFF;
                pulse = PULSE_MIN;
              end
            end
            WS_CALIBRATING: begin
              acted = 1'b1;
              if (countdown_expires()) begin
                pulse = PULSE_MIN;
                if (!range_phase) begin
                  range_phase = 1'b1;
                  countdown   = range_hold;
                end else begin
                  range_phase = 1'b0;
                  wheel       = WS_OFF;
                end
              end
            end
            default: ;
          endcase
        end
        KIND_ENABLE: begin
          if (it.enable_request && wheel == WS_OFF) begin
            acted     = 1'b1;
            wheel     = WS_TURNING_ON;
            pulse     = on_pulse;
            laser     = 1'b1;
            countdown = spin_delay;
          end else if (!it.enable_request &&
                       (wheel == WS_ON || wheel == WS_TURNING_ON)) begin
            // Pulse width holds until turning off expires.
            acted     = 1'b1;
            wheel     = WS_TURNING_OFF;
            laser     = 1'b0;
            stop_p    = (it.shooter_status == SHOOTER_RUNNING);
            countdown = spin_delay;
          end
        end
        KIND_STICK: begin
          if (wheel == WS_MANUAL) begin
            acted = 1'b1;
            v = 32'(it.stick_value);
            if (v > 32'(STICK_HIGH)) v = 32'(STICK_HIGH);
            else if (v < 32'(STICK_LOW)) v = 32'(STICK_LOW);
            pulse = 11'(32'(PULSE_MIN) + ((v - 32'(STICK_LOW)) * PULSE_SPAN) / STICK_SPAN);
          end
        end
        default: begin
          if (wheel == WS_PREPARE) begin
            acted = 1'b1;
            case (start_mode_e'(start_mode))
              START_NORMAL: begin
                pulse = PULSE_MIN;
                wheel = WS_OFF;
              end
              START_RANGE: begin
                pulse       = PULSE_MAX;
                range_phase = 1'b0;
                countdown   = range_hold;
                wheel       = WS_CALIBRATING;
              end
              START_MANUAL: wheel = WS_MANUAL;
              default: ;
            endcase
          end
        end
      endcase
      if (acted) words_acted++;
      r.pulse_us    = pulse;
      r.laser_en    = laser;
      r.fire_req    = start_p;
      r.fire_halt   = stop_p;
      r.wheel_state = wheel;
      states_seen[wheel] = 1'b1;
      pending_q.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      words_out++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: %h", got);
        failures++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("pulse_us", 32'(want.pulse_us), 32'(got.pulse_us));
      compare_field("laser_en", 32'(want.laser_en), 32'(got.laser_en));
      compare_field("fire_req", 32'(want.fire_req), 32'(got.fire_req));
      compare_field("fire_halt", 32'(want.fire_halt), 32'(got.fire_halt));
      compare_field("wheel_state", 32'(want.wheel_state), 32'(got.wheel_state));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // enable_request, stick_value, shooter_status
  logic [1:0]            s_axis_tuser;   // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;   // pulse_us, laser_en, fire_req,
                                         // fire_halt, wheel_state
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  flywheel_spinup_sequencer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  spinup_scoreboard sb = new();

  bit          hold_off_req;   // raised once by the sender side
  bit          hold_off_done;  // owned by the result sink
  bit          steady_burst;   // suppress sender gaps while set
  int unsigned burst_left;
  int unsigned cfg_phases;

  // --------------------------------------------------------------------------
  // Monitor: note accepted input words, check accepted result words
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    item_t   in_word;
    result_t out_word;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_word.kind           = s_axis_tuser;
        in_word.enable_request = s_axis_tdata[0];
        in_word.stick_value    = s_axis_tdata[11:1];
        in_word.shooter_status = s_axis_tdata[13:12];
        sb.note_input(in_word);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_word.pulse_us    = m_axis_tdata[10:0];
        out_word.laser_en    = m_axis_tdata[11];
        out_word.fire_req    = m_axis_tdata[12];
        out_word.fire_halt   = m_axis_tdata[13];
        out_word.wheel_state = m_axis_tdata[16:14];
        sb.check_result(out_word);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: stall in segments of different patterns; one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned seg_kind, seg_len, k;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      seg_kind = $urandom_range(0, 3);
      seg_len  = $urandom_range(4, 64);
      for (k = 0; k < seg_len; k++) begin
        @(posedge clk_i);
        if (hold_off_req && !hold_off_done) begin
          // Hold off long enough that both stream stages fill and input stalls.
          m_axis_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk_i);
          hold_off_done = 1'b1;
        end
        case (seg_kind)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= (k % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic item_t make_word(kind_e k, bit en, logic [10:0] stick, shooter_e sh);
    item_t it;
    it.kind           = k;
    it.enable_request = en;
    it.stick_value    = stick;
    it.shooter_status = sh;
    return it;
  endfunction

  function automatic shooter_e any_shooter();
    return shooter_e'($urandom_range(0, 3));
  endfunction

  // Random event word, tick-heavy so timed phases move along.
  function automatic item_t noise_word();
    int unsigned r;
    kind_e       k;
    r = $urandom_range(0, 9);
    if (r < 5) k = KIND_TICK;
    else if (r < 7) k = KIND_ENABLE;
    else if (r < 8) k = KIND_STICK;
    else k = KIND_START;
    return make_word(k, 1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                     any_shooter());
  endfunction

  // Offer one word, hold it until accepted, then maybe open a gap.
  task automatic send_word(input item_t it);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {2'b00, it.shooter_status, it.stick_value, it.enable_request};
    do @(posedge clk_i); while (!s_axis_tready);
    if (steady_burst) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and wait until every pending result has been checked.
  // Look between edges so the monitor has noted the last accepted word.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic reg_check(input reg_idx_e idx);
    logic [31:0] want, got;
    case (idx)
      REG_START_MODE: want = 32'(sb.start_mode);
      REG_ON_PULSE:   want = 32'(sb.on_pulse);
      REG_SPIN_DELAY: want = 32'(sb.spin_delay);
      default:        want = 32'(sb.range_hold);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("prdata mismatch at register %s: expected %0d, actual %0d",
             idx.name(), want, got);
      sb.failures++;
    end
    @(posedge clk_i);
  endtask

  // Well-formed spin cycle: enable, ticks through turning on (sometimes cut
  // short), disable, ticks through turning off.
  task automatic spin_cycle();
    int unsigned up_ticks, down_ticks, k;
    up_ticks   = sb.spin_delay + $urandom_range(0, 2);
    down_ticks = sb.spin_delay + $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) up_ticks = $urandom_range(0, up_ticks);
    send_word(make_word(KIND_ENABLE, 1'b1, 11'($urandom_range(0, 2047)), any_shooter()));
    for (k = 0; k < up_ticks; k++)
      send_word(make_word(KIND_TICK, 1'($urandom_range(0, 1)),
                          11'($urandom_range(0, 2047)), any_shooter()));
    send_word(make_word(KIND_ENABLE, 1'b0, 11'($urandom_range(0, 2047)), any_shooter()));
    for (k = 0; k < down_ticks; k++)
      send_word(make_word(KIND_TICK, 1'($urandom_range(0, 1)),
                          11'($urandom_range(0, 2047)), any_shooter()));
  endtask

  // Idle-time register phase: write every register, read one back.
  task automatic new_settings();
    drain();
    reg_write(REG_START_MODE, $urandom_range(0, 3));
    reg_write(REG_ON_PULSE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                        : $urandom_range(1000, 2000));
    reg_write(REG_SPIN_DELAY, ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(0, 6));
    reg_write(REG_RANGE_HOLD, $urandom_range(0, 4095));
    reg_check(reg_idx_e'($urandom_range(0, 3)));
    cfg_phases++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned start_path, next_cfg, hold_at, k;
    bit          pressure_done;
    string       path_name;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    burst_left    = 0;
    cfg_phases    = 0;
    pressure_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of all registers.
    reg_check(REG_START_MODE);
    reg_check(REG_ON_PULSE);
    reg_check(REG_SPIN_DELAY);
    reg_check(REG_RANGE_HOLD);

    // Prepare ignores everything but start.
    send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_READY));
    send_word(make_word(KIND_ENABLE, 1'b1, 11'd2047, SHOOTER_OTHER));
    send_word(make_word(KIND_ENABLE, 1'b0, 11'd0, SHOOTER_RUNNING));
    send_word(make_word(KIND_STICK, 1'b1, 11'd2047, SHOOTER_SPARE));
    drain();

    // Start mode three has no sequence: stay in prepare.
    reg_write(REG_START_MODE, 32'(START_NONE));
    send_word(make_word(KIND_START, 1'b0, 11'd0, SHOOTER_OTHER));
    drain();

    // Field extremes, written and read back before anything loads them.
    reg_write(REG_ON_PULSE, 32'h7FF);
    reg_write(REG_SPIN_DELAY, 32'hFFF);
    reg_write(REG_RANGE_HOLD, 32'hFFF);
    reg_check(REG_ON_PULSE);
    reg_check(REG_SPIN_DELAY);
    reg_check(REG_RANGE_HOLD);
    cfg_phases++;

    // The block leaves prepare only once per reset; let the seed pick the path.
    start_path = $urandom_range(0, 3);
    case (start_path)
      0: begin
        path_name = "normal";
        reg_write(REG_START_MODE, 32'(START_NORMAL));
        send_word(make_word(KIND_START, 1'b1, 11'd0, SHOOTER_OTHER));
        send_word(make_word(KIND_START, 1'b0, 11'd0, SHOOTER_OTHER));
      end
      1: begin
        path_name = "manual";
        reg_write(REG_START_MODE, 32'(START_MANUAL));
        send_word(make_word(KIND_START, 1'b0, 11'd0, SHOOTER_OTHER));
        // Clamp edges on both sides and the extremes of the field.
        send_word(make_word(KIND_STICK, 1'b0, 11'd0, SHOOTER_OTHER));
        send_word(make_word(KIND_STICK, 1'b1, 11'd1023, SHOOTER_READY));
        send_word(make_word(KIND_STICK, 1'b0, 11'd1024, SHOOTER_RUNNING));
        send_word(make_word(KIND_STICK, 1'b1, 11'd1025, SHOOTER_SPARE));
        send_word(make_word(KIND_STICK, 1'b0, 11'd1684, SHOOTER_OTHER));
        send_word(make_word(KIND_STICK, 1'b1, 11'd1685, SHOOTER_OTHER));
        send_word(make_word(KIND_STICK, 1'b0, 11'd2047, SHOOTER_OTHER));
        send_word(make_word(KIND_ENABLE, 1'b1, 11'd0, SHOOTER_READY));
        send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_READY));
        send_word(make_word(KIND_START, 1'b0, 11'd0, SHOOTER_OTHER));
      end
      default: begin
        path_name = "calibration";
        // Zero hold: each calibration pulse ends on the next tick.
        reg_write(REG_RANGE_HOLD, 32'd0);
        reg_write(REG_START_MODE, 32'(START_RANGE));
        send_word(make_word(KIND_START, 1'b0, 11'd0, SHOOTER_OTHER));
        send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_READY));
        send_word(make_word(KIND_START, 1'b0, 11'd0, SHOOTER_OTHER));
        send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_READY));
      end
    endcase
    drain();

    if (start_path != 1) begin
      // Zero spin delay and an out-of-range on pulse.
      reg_write(REG_SPIN_DELAY, 32'd0);
      reg_write(REG_ON_PULSE, 32'd0);
      reg_check(REG_ON_PULSE);
      send_word(make_word(KIND_ENABLE, 1'b0, 11'd0, SHOOTER_RUNNING));
      send_word(make_word(KIND_STICK, 1'b0, 11'd1500, SHOOTER_OTHER));
      send_word(make_word(KIND_ENABLE, 1'b1, 11'd0, SHOOTER_RUNNING));
      send_word(make_word(KIND_ENABLE, 1'b1, 11'd0, SHOOTER_OTHER));
      send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_READY));
      send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_READY));
      send_word(make_word(KIND_ENABLE, 1'b0, 11'd0, SHOOTER_RUNNING));
      send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_OTHER));
      drain();
      // Disable while still turning on replaces the pending turn-on.
      reg_write(REG_ON_PULSE, 32'd2000);
      reg_write(REG_SPIN_DELAY, 32'd1);
      send_word(make_word(KIND_ENABLE, 1'b1, 11'd0, SHOOTER_READY));
      send_word(make_word(KIND_ENABLE, 1'b0, 11'd0, SHOOTER_SPARE));
      send_word(make_word(KIND_TICK, 1'b0, 11'd0, SHOOTER_READY));
      drain();
      cfg_phases += 2;
    end

    // Random part: mostly spin cycles (or stick streams in manual), plus noise.
    next_cfg = sb.words_in + $urandom_range(80, 200);
    hold_at  = sb.words_in + $urandom_range(200, 600);
    while (sb.words_in < ITEMS_TOTAL) begin
      if (sb.words_in >= next_cfg) begin
        new_settings();
        next_cfg = sb.words_in + $urandom_range(80, 200);
      end
      if (!pressure_done && sb.words_in >= hold_at) begin
        // Keep offering back to back while the sink holds off.
        hold_off_req = 1'b1;
        steady_burst = 1'b1;
        for (k = 0; k < 24; k++) begin
          if (start_path == 1)
            send_word(make_word(KIND_STICK, 1'b0, 11'($urandom_range(0, 2047)),
                                any_shooter()));
          else
            send_word(noise_word());
        end
        steady_burst  = 1'b0;
        pressure_done = 1'b1;
      end
      if (start_path == 1) begin
        if ($urandom_range(0, 9) != 0)
          send_word(make_word(KIND_STICK, 1'($urandom_range(0, 1)),
                              11'($urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                       : $urandom_range(1000, 1710)),
                              any_shooter()));
        else
          send_word(noise_word());
      end else if ($urandom_range(0, 1)) begin
        spin_cycle();
      end else begin
        send_word(noise_word());
      end
    end

    drain();
    $display("Run covered the %s start path: %0d words in (%0d handled), %0d results checked",
             path_name, sb.words_in, sb.words_acted, sb.words_out);
    $display("Register settings applied: %0d; wheel states reached (bit per state): %b",
             cfg_phases, sb.states_seen);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Ends a run that hangs on a handshake.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
